FILE: rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB color converter.
// Holds the request and result structs and the hue reduction constants.
// No dependencies.
package hsv2rgb_pkg;

  typedef struct packed {
    logic signed [15:0] hue_degrees;
    logic signed [15:0] saturation;
    logic signed [15:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int unsigned HUE_FULL    = 360;
  localparam int unsigned SECTOR_DEG  = 60;
  // multiple of 360 that lifts any 16-bit signed hue above zero
  localparam int unsigned HUE_OFFSET  = 33120;
  localparam int unsigned RECIP_360   = 93207;
  localparam int unsigned RECIP_SHIFT = 25;

endpackage

FILE: rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter: seven-stage pipeline with a per-stage valid/ready chain.
// Depends on hsv2rgb_pkg for the request and result types and hue constants.
//
// Takes one HSV request per clock while hsv_ready is high and runs it through
// seven register stages. rgb_valid rises when the request reaches the last
// stage. Throughput is one pixel every cycle while rgb_ready stays high. A
// stall at the output stops only the stages that hold data, so bubbles fill
// while the result waits.
// Hue is reduced with a floored modulo 360 by reciprocal multiplication,
// saturation and brightness are clamped to 0..1.0 in Q1.FRAC_BITS, and every
// channel is floor(x * 255) exactly. Each stage holds at most two multipliers
// of about 20 by 20 bits.
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               hsv_valid,
  output logic               hsv_ready,
  input  hsv2rgb_pkg::hsv_t  hsv,
  output logic               rgb_valid,
  input  logic               rgb_ready,
  output hsv2rgb_pkg::rgb_t  rgb
);

  localparam int NSTAGE = 7;
  localparam int VW = FRAC_BITS + 1;
  localparam int AW = FRAC_BITS + 6;
  localparam int PW = VW + AW + 5;
  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam int unsigned SIXTY_S = hsv2rgb_pkg::SECTOR_DEG << FRAC_BITS;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  function automatic logic [VW-1:0] clamp_unit(input logic signed [15:0] x);
    logic [VW-1:0] res;
    if (x[15]) begin
      res = '0;
    end else if ({16'b0, x} > 32'(ONE)) begin
      res = VW'(ONE);
    end else begin
      res = VW'(x[14:0]);
    end
    return res;
  endfunction

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  logic [16:0]     x1, x2;
  logic [VW-1:0]   s1, s2, s3, s4;
  logic [VW-1:0]   v1, v2, v3, v4, v5;
  logic [7:0]      q2;
  logic [2*VW-1:0] pv2;
  logic [8:0]      m3;
  logic [7:0]      cv3, cv4, cv5, cv6;
  logic [7:0]      cp3, cp4, cp5, cp6;
  logic [2:0]      sec4, sec5, sec6;
  logic [5:0]      r4;
  logic [AW-1:0]   aq5, at5;
  logic [VW+AW-1:0] prq6, prt6;
  hsv2rgb_pkg::rgb_t rgb7;

  logic [33:0]      recip_prod;
  logic [8:0]       m_next;
  logic [VW+7:0]    wv;
  logic [2*VW+7:0]  wp;
  logic [2:0]       sec_next;
  logic [5:0]       r_next;
  logic [5:0]       rc;
  logic [VW+5:0]    sr, st;
  logic [PW-1:0]    lq, lt;
  logic [7:0]       cq, ct;
  hsv2rgb_pkg::rgb_t rgb_next;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || rgb_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign hsv_ready = en[0];
  assign rgb_valid = vld[NSTAGE-1];
  assign rgb       = rgb7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? hsv_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_comb begin
    recip_prod = 34'(x1) * 34'(hsv2rgb_pkg::RECIP_360);
    m_next = 9'(x2 - 17'(q2) * 17'(hsv2rgb_pkg::HUE_FULL));
    wv = {v2, 8'b0} - {8'b0, v2};
    wp = {pv2, 8'b0} - {8'b0, pv2};
    sec_next = '0;
    for (int k = 1; k < 6; k++) begin
      if (m3 >= 9'(hsv2rgb_pkg::SECTOR_DEG * k)) begin
        sec_next = 3'(k);
      end
    end
    r_next = 6'(m3 - 9'(sec_next) * 9'(hsv2rgb_pkg::SECTOR_DEG));
    rc = 6'(hsv2rgb_pkg::SECTOR_DEG - 32'(r4));
    sr = s4 * r4;
    st = s4 * rc;
    lq = {prq6, 5'b0} - {prq6, 4'b0} + PW'(prq6);
    lt = {prt6, 5'b0} - {prt6, 4'b0} + PW'(prt6);
    cq = 8'(lq >> (2 * FRAC_BITS + 2));
    ct = 8'(lt >> (2 * FRAC_BITS + 2));
    case (sector_t'(sec6))
      SEC_YELLOW:  rgb_next = '{red: cq,  green: cv6, blue: cp6};
      SEC_GREEN:   rgb_next = '{red: cp6, green: cv6, blue: ct};
      SEC_CYAN:    rgb_next = '{red: cp6, green: cq,  blue: cv6};
      SEC_BLUE:    rgb_next = '{red: ct,  green: cp6, blue: cv6};
      SEC_MAGENTA: rgb_next = '{red: cv6, green: cp6, blue: cq};
      SEC_RED:     rgb_next = '{red: cv6, green: ct,  blue: cp6};
      default:     rgb_next = '{red: cv6, green: ct,  blue: cp6};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1 <= {hsv.hue_degrees[15], hsv.hue_degrees} + 17'(hsv2rgb_pkg::HUE_OFFSET);
      s1 <= clamp_unit(hsv.saturation);
      v1 <= clamp_unit(hsv.brightness);
    end
    if (en[1]) begin
      q2  <= 8'(recip_prod >> hsv2rgb_pkg::RECIP_SHIFT);
      x2  <= x1;
      s2  <= s1;
      v2  <= v1;
      pv2 <= v1 * (VW'(ONE) - s1);
    end
    if (en[2]) begin
      m3  <= m_next;
      s3  <= s2;
      v3  <= v2;
      cv3 <= 8'(wv >> FRAC_BITS);
      cp3 <= 8'(wp >> (2 * FRAC_BITS));
    end
    if (en[3]) begin
      sec4 <= sec_next;
      r4   <= r_next;
      s4   <= s3;
      v4   <= v3;
      cv4  <= cv3;
      cp4  <= cp3;
    end
    if (en[4]) begin
      aq5  <= AW'(SIXTY_S) - AW'(sr);
      at5  <= AW'(SIXTY_S) - AW'(st);
      v5   <= v4;
      sec5 <= sec4;
      cv5  <= cv4;
      cp5  <= cp4;
    end
    if (en[5]) begin
      prq6 <= v5 * aq5;
      prt6 <= v5 * at5;
      sec6 <= sec5;
      cv6  <= cv5;
      cp6  <= cp5;
    end
    if (en[6]) begin
      rgb7 <= rgb_next;
    end
  end

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(vld) == $past($countones(vld))
      + int'($past(hsv_valid && hsv_ready)) - int'($past(rgb_valid && rgb_ready)))
    else $error("pipeline occupancy does not match accepted requests");

  a_hue_mod: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> m3 < 9'(hsv2rgb_pkg::HUE_FULL))
    else $error("hue reduction out of range");

  a_sector: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> sec4 < 3'd6 && r4 < 6'(hsv2rgb_pkg::SECTOR_DEG))
    else $error("sector split out of range");
`endif

endmodule
